FILE: rtl/mmcs_pkg.sv
// shared constants, codes and handshake structs for the matrix multiply block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package mmcs_pkg;

  // field widths
  localparam int MODE_W      = 3;
  localparam int IDX_FIELD_W = 3;
  localparam int VALUE_W     = 16;
  localparam int KIND_W      = 2;
  localparam int RESULT_W    = 48;
  localparam int ORDER_W     = 4;
  localparam int PROD_W      = 2 * VALUE_W;

  localparam int                 DEF_MAX_ORDER = 8;
  localparam logic [ORDER_W-1:0] ORDER_RESET   = 4'd8;

  // input transaction modes
  localparam logic [MODE_W-1:0] MODE_WR_A      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_WR_B      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_COMPUTE   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RD_ENTRY  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RD_COLSUM = 3'd4;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_TOTAL  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ENTRY  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COLSUM = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic              wr_a;
    logic              wr_b;
    logic              rd_prod;
    logic              rd_col;
    logic              clr_total;
    logic              mac_vld;
    logic              k_first;
    logic              k_last;
    logic              i_first;
    logic              i_last;
    logic              all_last;
    logic              out_load;
    logic [KIND_W-1:0] out_kind;
    logic              out_err;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic mac_done;
    logic out_free;
  } stat_t;

endpackage

FILE: rtl/matrix_multiply_column_sum.sv
// square matrix multiply with column sums and grand total, signed q8.8 in, q32.16 out
// all multiply-accumulates share one 16x16 multiplier fed from the a/b memories
// throughput: writes one per cycle; reads and computes hold the input until their result is loaded
// reset (rst_ni low, async): control idle, order = 8, grand total zero; stores undefined
// depends on mmcs_pkg, mmcs_ctrl, mmcs_dp
`timescale 1ns / 1ps

module matrix_multiply_column_sum #(
  parameter int MAX_ORDER = mmcs_pkg::DEF_MAX_ORDER
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: order
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  // input transactions
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // row [2:0], col [5:3], value [21:6], zero pad [23:22]
  input  logic [2:0]  s_axis_tuser_i,   // mode [2:0]
  // result transactions
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // result [47:0]
  output logic [2:0]  m_axis_tuser_o    // kind [1:0], index_error [2]
);
  import mmcs_pkg::*;

  localparam int IDX_W = $clog2(MAX_ORDER);

  cmd_t                      cmd;
  stat_t                     stat;
  logic [2*IDX_W-1:0]        wr_addr;
  logic [IDX_W-1:0]          col_idx;
  logic [IDX_W-1:0]          mac_i, mac_j, mac_k;
  logic [IDX_FIELD_W-1:0]    in_row, in_col;
  logic signed [VALUE_W-1:0] in_value;
  logic [KIND_W-1:0]         out_kind;
  logic                      out_err;

  // unpack the input transaction
  assign in_row   = s_axis_tdata_i[2:0];
  assign in_col   = s_axis_tdata_i[5:3];
  assign in_value = s_axis_tdata_i[21:6];

  // controller: decodes modes, checks indices against the order, walks j, i, k
  mmcs_ctrl #(
    .MAX_ORDER(MAX_ORDER)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_valid_i  (s_axis_tvalid_i),
    .s_ready_o  (s_axis_tready_o),
    .mode_i     (s_axis_tuser_i),
    .row_i      (in_row),
    .col_i      (in_col),
    .cmd_o      (cmd),
    .stat_i     (stat),
    .wr_addr_o  (wr_addr),
    .col_idx_o  (col_idx),
    .mac_i_o    (mac_i),
    .mac_j_o    (mac_j),
    .mac_k_o    (mac_k)
  );

  // datapath: memories, fetch/multiply/accumulate pipeline, output register
  mmcs_dp #(
    .MAX_ORDER(MAX_ORDER)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .wr_addr_i (wr_addr),
    .col_idx_i (col_idx),
    .value_i   (in_value),
    .mac_i_i   (mac_i),
    .mac_j_i   (mac_j),
    .mac_k_i   (mac_k),
    .m_ready_i (m_axis_tready_i),
    .m_valid_o (m_axis_tvalid_o),
    .m_kind_o  (out_kind),
    .m_result_o(m_axis_tdata_o),
    .m_err_o   (out_err)
  );

  // pack result sideband
  assign m_axis_tuser_o = {out_err, out_kind};

endmodule

FILE: rtl/mmcs_dp.sv
// datapath: matrix memories, multiply-accumulate pipeline, sum stores, output register
// depends on mmcs_pkg
`timescale 1ns / 1ps

module mmcs_dp #(
  parameter int  MAX_ORDER = mmcs_pkg::DEF_MAX_ORDER,
  localparam int IDX_W     = $clog2(MAX_ORDER)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mmcs_pkg::cmd_t                      cmd_i,
  output mmcs_pkg::stat_t                     stat_o,
  input  logic [2*IDX_W-1:0]                  wr_addr_i,
  input  logic [IDX_W-1:0]                    col_idx_i,
  input  logic signed [mmcs_pkg::VALUE_W-1:0] value_i,
  input  logic [IDX_W-1:0]                    mac_i_i,
  input  logic [IDX_W-1:0]                    mac_j_i,
  input  logic [IDX_W-1:0]                    mac_k_i,
  input  logic                                m_ready_i,
  output logic                                m_valid_o,
  output logic [mmcs_pkg::KIND_W-1:0]         m_kind_o,
  output logic [mmcs_pkg::RESULT_W-1:0]       m_result_o,
  output logic                                m_err_o
);
  import mmcs_pkg::*;

  localparam int ADDR_W    = 2 * IDX_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int COL_DEPTH = 1 << IDX_W;
  localparam int C_W       = PROD_W + IDX_W;
  localparam int COL_W     = C_W + IDX_W;
  localparam int TOT_W     = COL_W + IDX_W;

  typedef struct packed {
    logic             vld;
    logic             k_first;
    logic             k_last;
    logic             i_first;
    logic             i_last;
    logic             all_last;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
  } tag_t;

  logic signed [VALUE_W-1:0] mem_a [MEM_DEPTH];
  logic signed [VALUE_W-1:0] mem_b [MEM_DEPTH];
  logic signed [C_W-1:0]     mem_p [MEM_DEPTH];
  logic signed [COL_W-1:0]   mem_c [COL_DEPTH];

  logic signed [VALUE_W-1:0] a_q, b_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [C_W-1:0]     acc_q, acc_base;
  logic signed [COL_W-1:0]   col_q, col_base;
  logic signed [TOT_W-1:0]   total_q;
  logic signed [C_W-1:0]     prod_rd_q;
  logic signed [COL_W-1:0]   col_rd_q;
  tag_t                      t1_q, t2_q, t3_q, t4_q, t5_q;

  logic                      out_vld_q;
  logic [KIND_W-1:0]         out_kind_q;
  logic [RESULT_W-1:0]       out_res_q, out_res_d;
  logic                      out_err_q;

  // matrix loads
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_a) begin
      mem_a[wr_addr_i] <= value_i;
    end
    if (cmd_i.wr_b) begin
      mem_b[wr_addr_i] <= value_i;
    end
  end

  // operand fetch: a[i][k] and b[k][j]
  always_ff @(posedge clk_i) begin
    if (cmd_i.mac_vld) begin
      a_q <= mem_a[{mac_i_i, mac_k_i}];
      b_q <= mem_b[{mac_k_i, mac_j_i}];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q <= '0;
      t2_q <= '0;
      t3_q <= '0;
      t4_q <= '0;
      t5_q <= '0;
    end else begin
      t1_q <= '{vld: cmd_i.mac_vld, k_first: cmd_i.k_first, k_last: cmd_i.k_last,
                i_first: cmd_i.i_first, i_last: cmd_i.i_last, all_last: cmd_i.all_last,
                i: mac_i_i, j: mac_j_i};
      t2_q <= t1_q;
      t3_q <= t2_q;
      t4_q <= t3_q;
      t5_q <= t4_q;
    end
  end

  assign acc_base = t2_q.k_first ? '0 : acc_q;
  assign col_base = t3_q.i_first ? '0 : col_q;

  // multiply, accumulate over k, then fold into column and grand sums
  always_ff @(posedge clk_i) begin
    if (t1_q.vld) begin
      prod_q <= a_q * b_q;
    end
    if (t2_q.vld) begin
      acc_q <= acc_base + C_W'(prod_q);
    end
    if (t3_q.vld && t3_q.k_last) begin
      mem_p[{t3_q.i, t3_q.j}] <= acc_q;
      col_q                  <= col_base + COL_W'(acc_q);
    end
    if (t4_q.vld && t4_q.k_last && t4_q.i_last) begin
      mem_c[t4_q.j] <= col_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (cmd_i.clr_total) begin
      total_q <= '0;
    end else if (t4_q.vld && t4_q.k_last && t4_q.i_last) begin
      total_q <= total_q + TOT_W'(col_q);
    end
  end

  // read ports for stored results
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_prod) begin
      prod_rd_q <= mem_p[wr_addr_i];
    end
    if (cmd_i.rd_col) begin
      col_rd_q <= mem_c[col_idx_i];
    end
  end

  always_comb begin
    case (cmd_i.out_kind)
      KIND_TOTAL:  out_res_d = RESULT_W'(total_q);
      KIND_ENTRY:  out_res_d = RESULT_W'(prod_rd_q);
      KIND_COLSUM: out_res_d = RESULT_W'(col_rd_q);
      default:     out_res_d = '0;
    endcase
    if (cmd_i.out_err) begin
      out_res_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_kind_q <= cmd_i.out_kind;
      out_res_q  <= out_res_d;
      out_err_q  <= cmd_i.out_err;
    end
  end

  assign stat_o.mac_done = t5_q.vld && t5_q.all_last;
  assign stat_o.out_free = !out_vld_q || m_ready_i;

  assign m_valid_o  = out_vld_q;
  assign m_kind_o   = out_kind_q;
  assign m_result_o = out_res_q;
  assign m_err_o    = out_err_q;

endmodule

FILE: rtl/mmcs_ctrl.sv
// controller: order register, command decode and the j/i/k loop sequencer
// depends on mmcs_pkg
`timescale 1ns / 1ps

module mmcs_ctrl #(
  parameter int  MAX_ORDER = mmcs_pkg::DEF_MAX_ORDER,
  localparam int IDX_W     = $clog2(MAX_ORDER)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mmcs_pkg::ORDER_W-1:0]        cfg_wdata_i,
  input  logic                                s_valid_i,
  output logic                                s_ready_o,
  input  logic [mmcs_pkg::MODE_W-1:0]         mode_i,
  input  logic [mmcs_pkg::IDX_FIELD_W-1:0]    row_i,
  input  logic [mmcs_pkg::IDX_FIELD_W-1:0]    col_i,
  output mmcs_pkg::cmd_t                      cmd_o,
  input  mmcs_pkg::stat_t                     stat_i,
  output logic [2*IDX_W-1:0]                  wr_addr_o,
  output logic [IDX_W-1:0]                    col_idx_o,
  output logic [IDX_W-1:0]                    mac_i_o,
  output logic [IDX_W-1:0]                    mac_j_o,
  output logic [IDX_W-1:0]                    mac_k_o
);
  import mmcs_pkg::*;

  localparam int OW = $clog2(MAX_ORDER + 1);
  localparam int CW = (OW > ORDER_W) ? OW : ORDER_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MAC   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_RESP  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [ORDER_W-1:0] order_q;
  logic [IDX_W-1:0]   i_q, i_d, j_q, j_d, k_q, k_d;
  logic [KIND_W-1:0]  kind_q, kind_d;
  logic               err_q, err_d;

  logic [CW-1:0] order_x, max_x, n_x, n_m1, row_x, col_x;
  logic          rc_ok, c_ok, n_zero, accept;
  logic          k_last, i_last, j_last;

  // effective order saturates at the array size
  assign order_x = CW'(order_q);
  assign max_x   = CW'(MAX_ORDER);
  assign n_x     = (order_x > max_x) ? max_x : order_x;
  assign n_m1    = n_x - CW'(1);
  assign n_zero  = (n_x == '0);
  assign row_x   = CW'(row_i);
  assign col_x   = CW'(col_i);
  assign c_ok    = (col_x < n_x);
  assign rc_ok   = (row_x < n_x) && c_ok;

  assign k_last = (CW'(k_q) == n_m1);
  assign i_last = (CW'(i_q) == n_m1);
  assign j_last = (CW'(j_q) == n_m1);

  assign s_ready_o = (state_q == ST_IDLE);
  assign accept    = s_valid_i && s_ready_o;

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    kind_d  = kind_q;
    err_d   = err_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (mode_i)
            MODE_WR_A: cmd_o.wr_a = rc_ok;
            MODE_WR_B: cmd_o.wr_b = rc_ok;
            MODE_COMPUTE: begin
              cmd_o.clr_total = 1'b1;
              kind_d          = KIND_TOTAL;
              err_d           = 1'b0;
              i_d             = '0;
              j_d             = '0;
              k_d             = '0;
              state_d         = n_zero ? ST_RESP : ST_MAC;
            end
            MODE_RD_ENTRY: begin
              cmd_o.rd_prod = rc_ok;
              kind_d        = KIND_ENTRY;
              err_d         = !rc_ok;
              state_d       = ST_RESP;
            end
            MODE_RD_COLSUM: begin
              cmd_o.rd_col = c_ok;
              kind_d       = KIND_COLSUM;
              err_d        = !c_ok;
              state_d      = ST_RESP;
            end
            default: ;
          endcase
        end
      end
      ST_MAC: begin
        cmd_o.mac_vld  = 1'b1;
        cmd_o.k_first  = (k_q == '0);
        cmd_o.k_last   = k_last;
        cmd_o.i_first  = (i_q == '0);
        cmd_o.i_last   = i_last;
        cmd_o.all_last = k_last && i_last && j_last;
        if (k_last) begin
          k_d = '0;
          if (i_last) begin
            i_d = '0;
            if (j_last) begin
              j_d     = '0;
              state_d = ST_DRAIN;
            end else begin
              j_d = j_q + IDX_W'(1);
            end
          end else begin
            i_d = i_q + IDX_W'(1);
          end
        end else begin
          k_d = k_q + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (stat_i.mac_done) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    cmd_o.out_kind = kind_q;
    cmd_o.out_err  = err_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      order_q <= ORDER_RESET;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      kind_q  <= KIND_TOTAL;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      kind_q  <= kind_d;
      err_q   <= err_d;
      if (cfg_we_i) begin
        order_q <= cfg_wdata_i;
      end
    end
  end

  assign wr_addr_o = {row_x[IDX_W-1:0], col_x[IDX_W-1:0]};
  assign col_idx_o = col_x[IDX_W-1:0];
  assign mac_i_o   = i_q;
  assign mac_j_o   = j_q;
  assign mac_k_o   = k_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> stat_i.out_free)
    else $error("result loaded over an unaccepted transaction");

  a_done_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.mac_done |-> (state_q == ST_DRAIN))
    else $error("pipeline finished outside drain");

  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.wr_a || cmd_o.wr_b) |-> (accept && !cmd_o.mac_vld))
    else $error("matrix write without an input transaction");

  a_mac_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mac_vld |=> (state_q == ST_MAC || state_q == ST_DRAIN))
    else $error("loop left without draining");

endmodule
